// ===== rtl/core/fkg_pkg.sv =====
// Package for the fractional knapsack block: widths, constants, state codes.
// Used by fkg_div and the top level; depends on nothing.
`default_nettype none
package fkg_pkg;
  localparam int unsigned DefMaxItems = 64;
  localparam int unsigned ValW   = 16;
  localparam int unsigned CapW   = 24;
  localparam int unsigned TotW   = 38;
  localparam int unsigned FracW  = 16;
  localparam int unsigned EntW   = 32;  // {weight, value}
  localparam int unsigned DivW   = 56;  // value*remain << 16 fits in 56 bits

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT,
    ST_FILL_RD, ST_FILL_CHK, ST_FRAC_MUL, ST_DIV, ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/core/fkg_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module fkg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // one access a cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/fkg_div.sv =====
// Restoring divider, one quotient bit a cycle, for the fractional item.
// Depends on fkg_pkg.
`default_nettype none
module fkg_div import fkg_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [ValW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DivW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);
  logic [DivW-1:0] quot_q, quot_d;
  logic [ValW:0]   rem_q, rem_d;
  logic [ValW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [ValW:0]   trial;

  // shift one dividend bit into the remainder, subtract if it fits
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[ValW-1:0], quot_q[DivW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quot_d;
endmodule
`default_nettype wire

// ===== rtl/core/fractional_knapsack_greedy_top.sv =====
// Top level of the fractional knapsack block: sequencer around the item RAM.
// Depends on fkg_pkg, fkg_ram and fkg_div.
//
//  channel   dir  beat content
//  s_axis    in   tdata {weight[31:16], value[15:0]}, tlast = last item
//  cfg       in   cfg_data_i = capacity[23:0]
//  m_axis    out  tdata {pad, overflow[62], weight[61:38], total q16[37:0]}
//
// Insertion: each scanned entry takes a read and a compare state, and each shifted
// entry a read and a write state, all through the single RAM port. A last item
// then walks the store (a read and a check state per entry) and may run the
// restoring divider. Reset clears count, flag and capacity. The result
// sits in an output register; s_axis waits while it is unread.
`default_nettype none
module fractional_knapsack_greedy_top import fkg_pkg::*; #(
  parameter int unsigned MaxItems = DefMaxItems
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value, weight
  input  wire logic        s_axis_tlast,   // last_item
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [CapW-1:0] cfg_data_i, // capacity
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // total_value_q16, taken_weight, overflow
);
  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned NW = $clog2(MaxItems + 1);
  // room for every whole item before the result saturates
  localparam int unsigned SumW = TotW + NW;
  localparam int unsigned PrW = ValW + CapW;

  state_e state_q, state_d;
  logic [CapW-1:0] cap_q;
  logic [NW-1:0] cnt_q, cnt_d, pos_q, pos_d, k_q, k_d;
  logic drop_q, drop_d, last_q, last_d;
  logic [ValW-1:0] v_q, v_d, w_q, w_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CapW:0] used_q, used_d;
  logic [DivW-1:0] prod_q, prod_d;
  logic [TotW-1:0] res_tot_q;
  logic [CapW-1:0] res_w_q;
  logic res_ov_q, res_v_q;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [EntW-1:0] ram_wdata, ram_rdata;
  logic div_start, div_done;
  logic [DivW-1:0] div_q;
  logic [ValW-1:0] rd_v, rd_w;
  logic [2*ValW-1:0] lhs, rhs;
  logic [CapW:0] fit;
  logic [SumW-1:0] sum_add;
  logic [CapW-1:0] remain;
  logic [PrW-1:0] frac_prod;

  fkg_ram #(.Width(EntW), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  fkg_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_q),
    .divisor_i(rd_w), .done_o(div_done), .quot_o(div_q)
  );

  assign rd_v = ram_rdata[ValW-1:0];
  assign rd_w = ram_rdata[EntW-1:ValW];
  assign lhs  = v_q * rd_w;
  assign rhs  = rd_v * w_q;
  assign fit  = used_q + {{(CapW-ValW+1){1'b0}}, rd_w};
  assign remain = cap_q - used_q[CapW-1:0];
  assign frac_prod = PrW'(rd_v) * PrW'(remain);

  assign s_axis_tready = (state_q == ST_IDLE) && !res_v_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = {1'b0, res_ov_q, res_w_q, res_tot_q};

  // sequencer: scan, shift, insert, then walk the store on the last item
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pos_d = pos_q; k_d = k_q;
    drop_d = drop_q; last_d = last_q; v_d = v_q; w_d = w_q;
    sum_d = sum_q; used_d = used_q; prod_d = prod_q;
    ram_we = 1'b0; ram_addr = pos_q[AW-1:0]; ram_wdata = {w_q, v_q};
    div_start = 1'b0; sum_add = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          v_d = s_axis_tdata[ValW-1:0];
          w_d = s_axis_tdata[2*ValW-1:ValW];
          last_d = s_axis_tlast;
          pos_d = '0;
          if (cnt_q == NW'(MaxItems)) begin
            drop_d = 1'b1;
            state_d = s_axis_tlast ? ST_FILL_RD : ST_IDLE;
            k_d = '0; sum_d = '0; used_d = '0;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        ram_addr = pos_q[AW-1:0];
        state_d = (pos_q == cnt_q) ? ST_PUT : ST_SCAN_CMP;
        k_d = cnt_q;
      end
      ST_SCAN_CMP: begin
        if (lhs > rhs) begin
          state_d = ST_SHIFT_RD;
        end else begin
          pos_d = pos_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (k_q == pos_q) begin
          state_d = ST_PUT;
        end else begin
          ram_addr = AW'(k_q - 1'b1);
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        ram_we = 1'b1; ram_addr = k_q[AW-1:0]; ram_wdata = ram_rdata;
        k_d = k_q - 1'b1;
        state_d = ST_SHIFT_RD;
      end
      ST_PUT: begin
        ram_we = 1'b1; ram_addr = pos_q[AW-1:0]; ram_wdata = {w_q, v_q};
        cnt_d = cnt_q + 1'b1;
        k_d = '0; sum_d = '0; used_d = '0;
        state_d = last_q ? ST_FILL_RD : ST_IDLE;
      end
      ST_FILL_RD: begin
        ram_addr = k_q[AW-1:0];
        state_d = (k_q == cnt_q) ? ST_OUT : ST_FILL_CHK;
      end
      ST_FILL_CHK: begin
        // keep the entry on the read port so the divider sees its weight
        ram_addr = k_q[AW-1:0];
        if (fit <= {1'b0, cap_q}) begin
          used_d = fit;
          sum_add = {{(SumW-ValW-FracW){1'b0}}, rd_v, {FracW{1'b0}}};
          sum_d = sum_q + sum_add;
          k_d = k_q + 1'b1;
          state_d = ST_FILL_RD;
        end else begin
          prod_d = {frac_prod, {FracW{1'b0}}};
          used_d = {1'b0, cap_q};
          state_d = ST_FRAC_MUL;
        end
      end
      ST_FRAC_MUL: begin
        div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          sum_d = sum_q + SumW'(div_q);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cnt_d = '0; drop_d = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; drop_q <= 1'b0;
      cap_q <= '0; res_v_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; drop_q <= drop_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (state_q == ST_OUT) begin
        res_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  // payload and result registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; k_q <= k_d; last_q <= last_d; v_q <= v_d; w_q <= w_d;
    sum_q <= sum_d; used_q <= used_d; prod_q <= prod_d;
    if (state_q == ST_OUT) begin
      res_tot_q <= (|sum_q[SumW-1:TotW]) ? {TotW{1'b1}} : sum_q[TotW-1:0];
      res_w_q   <= used_q[CapW-1:0];
      res_ov_q  <= drop_q;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MaxItems)) else $error("item count above store depth");
  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> cnt_q == '0 && !drop_q) else $error("store not cleared");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready) else $error("accepted while busy");
endmodule
`default_nettype wire
